// ----- sv/hashed_actor_table_macros.svh -----
// Assertion macros for the actor table checker.
// Expects signals clk and arst_n in the scope of each use.
`ifndef HASHED_ACTOR_TABLE_MACROS_SVH
`define HASHED_ACTOR_TABLE_MACROS_SVH

// same-cycle implication
`define HAT_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define HAT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- sv/hat_pkg.sv -----
`timescale 1ns / 1ps
// Shared widths, codes and word types of the hashed actor table.
// No dependencies; imported by hat_mod, hashed_actor_table and hat_checker.
package hat_pkg;

	localparam int BUCKETS_DEF = 128;
	localparam int WAYS_DEF    = 4;

	localparam int CMD_W    = 2;
	localparam int KEY_W    = 32;
	localparam int HANDLE_W = 32;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 10;
	localparam int SUM_W    = KEY_W + 1;

	localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd0;
	localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
	localparam logic [CMD_W-1:0] CMD_DELETE = 2'd2;

	localparam logic [STATUS_W-1:0] STAT_OK   = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_MISS = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_DUP  = 2'd2;
	localparam logic [STATUS_W-1:0] STAT_FULL = 2'd3;

	typedef struct packed {
		logic [CMD_W-1:0]    command;
		logic [KEY_W-1:0]    entity_key;
		logic [KEY_W-1:0]    process_key;
		logic [HANDLE_W-1:0] handle_in;
	} req_word_t;

	typedef struct packed {
		logic                found;
		logic [HANDLE_W-1:0] handle_out;
		logic [STATUS_W-1:0] status;
		logic [COUNT_W-1:0]  live_count;
	} rsp_word_t;

endpackage

// ----- sv/hat_if.sv -----
`timescale 1ns / 1ps
// Valid/ready channel carrying one word of type word_t.
// Used with hat_pkg word types.
interface hat_if #(parameter type word_t = logic);
	logic  valid;
	logic  ready;
	word_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- sv/hat_ram.sv -----
`timescale 1ns / 1ps
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module hat_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- sv/hat_mod.sv -----
`timescale 1ns / 1ps
// Bucket index unit: 33-bit key sum modulo BUCKETS.
// Power-of-two counts register the low sum bits, others four bits a cycle. Uses hat_pkg.
module hat_mod #(
	parameter int BUCKETS = hat_pkg::BUCKETS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [hat_pkg::SUM_W-1:0]  sum,
	output logic                       done,
	output logic [$clog2(BUCKETS)-1:0] bucket
);
	import hat_pkg::*;

	localparam int  ABITS   = $clog2(BUCKETS);
	localparam bit  IS_POW2 = (BUCKETS & (BUCKETS - 1)) == 0;
	localparam int  NDIG    = (SUM_W + 3) / 4;
	localparam int  PADW    = NDIG * 4;
	localparam int  TW      = ABITS + 4;
	localparam int  IW      = $clog2(NDIG);

	generate
		if (IS_POW2) begin : g_pow2
			logic             done_q;
			logic [ABITS-1:0] bucket_q;

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					done_q <= 1'b0;
				end else begin
					done_q <= start;
				end
			end

			always_ff @(posedge clk) begin
				if (start) begin
					bucket_q <= sum[ABITS-1:0];
				end
			end

			assign done   = done_q;
			assign bucket = bucket_q;
		end else begin : g_iter
			logic             busy_q;
			logic             done_q;
			logic [IW-1:0]    idx_q;
			logic [PADW-1:0]  pad_q;
			logic [ABITS-1:0] rem_q;
			logic [ABITS-1:0] rem_nxt;

			always_comb begin
				logic [TW-1:0] t;
				logic [TW-1:0] bk;
				t = {rem_q, pad_q[PADW-1 -: 4]};
				for (int k = 3; k >= 0; k--) begin
					bk = TW'(BUCKETS) << k;
					if (t >= bk) begin
						t = t - bk;
					end
				end
				rem_nxt = t[ABITS-1:0];
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					busy_q <= 1'b0;
					done_q <= 1'b0;
					idx_q  <= '0;
				end else begin
					done_q <= busy_q && (idx_q == '0);
					if (start) begin
						busy_q <= 1'b1;
						idx_q  <= IW'(NDIG - 1);
					end else if (busy_q) begin
						if (idx_q == '0) begin
							busy_q <= 1'b0;
						end else begin
							idx_q <= idx_q - 1'b1;
						end
					end
				end
			end

			always_ff @(posedge clk) begin
				if (start) begin
					pad_q <= PADW'(sum);
					rem_q <= '0;
				end else if (busy_q) begin
					pad_q <= pad_q << 4;
					rem_q <= rem_nxt;
				end
			end

			assign done   = done_q;
			assign bucket = rem_q;
		end
	endgenerate

endmodule

// ----- sv/hashed_actor_table.sv -----
`timescale 1ns / 1ps
// Hashed actor table: search, insert, delete on BUCKETS buckets of WAYS ways.
// One word at a time: a request is taken only in idle, after the last word's
// response is registered; the bucket modulo unit sets the hash step length.
// Reset: a pass over all BUCKETS rows clears the valid-mark RAM, no word taken meanwhile.
// Depends on hat_pkg, hat_if, hat_ram, hat_mod.
module hashed_actor_table #(
	parameter int BUCKETS = hat_pkg::BUCKETS_DEF,
	parameter int WAYS    = hat_pkg::WAYS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	hat_if.sink  req,
	hat_if.source rsp
);
	import hat_pkg::*;

	localparam int ABITS = $clog2(BUCKETS);
	localparam int SLOTS = BUCKETS * WAYS;
	localparam int CNT_W = $clog2(SLOTS + 1);
	localparam int KW    = 2 * KEY_W;
	localparam int WAY_W = KW + HANDLE_W;
	localparam int ROW_W = WAYS * WAY_W;
	localparam logic [ABITS-1:0] LAST_ROW = ABITS'(BUCKETS - 1);

	localparam logic [1:0] S_CLEAR = 2'd0;
	localparam logic [1:0] S_IDLE  = 2'd1;
	localparam logic [1:0] S_HASH  = 2'd2;
	localparam logic [1:0] S_CMP   = 2'd3;

	logic [1:0]          state_q;
	logic [ABITS-1:0]    clr_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [CNT_W-1:0]    cnt_nxt;
	logic [CMD_W-1:0]    cmd_q;
	logic [KW-1:0]       key_q;
	logic [HANDLE_W-1:0] hin_q;
	logic [ABITS-1:0]    bkt_q;
	logic                rsp_valid_q;
	rsp_word_t           rsp_q;
	rsp_word_t           rsp_nxt;

	logic                accept;
	logic                finish;
	logic                mod_done;
	logic [ABITS-1:0]    mod_bucket;
	logic [SUM_W-1:0]    key_sum;

	logic                v_we;
	logic [ABITS-1:0]    v_waddr;
	logic [WAYS-1:0]     v_wdata;
	logic [WAYS-1:0]     v_row;
	logic                d_we;
	logic [ROW_W-1:0]    d_row;
	logic [ROW_W-1:0]    d_wdata;
	logic                rd_en;

	logic [WAYS-1:0]     hit_vec;
	logic [WAYS-1:0]     low_free;
	logic [WAYS-1:0]     v_row_nxt;
	logic [HANDLE_W-1:0] hit_handle;
	logic                v_upd;

	assign accept  = req.valid && req.ready;
	assign key_sum = {1'b0, req.data.entity_key} + {1'b0, req.data.process_key};
	assign rd_en   = (state_q == S_HASH) && mod_done;
	assign finish  = (state_q == S_CMP) && (!rsp_valid_q || rsp.ready);

	assign req.ready = (state_q == S_IDLE);
	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_q;

	hat_mod #(.BUCKETS(BUCKETS)) u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept),
		.sum    (key_sum),
		.done   (mod_done),
		.bucket (mod_bucket)
	);

	hat_ram #(.WIDTH(WAYS), .DEPTH(BUCKETS)) u_valid_ram (
		.clk   (clk),
		.we    (v_we),
		.waddr (v_waddr),
		.wdata (v_wdata),
		.re    (rd_en),
		.raddr (mod_bucket),
		.rdata (v_row)
	);

	hat_ram #(.WIDTH(ROW_W), .DEPTH(BUCKETS)) u_data_ram (
		.clk   (clk),
		.we    (d_we),
		.waddr (bkt_q),
		.wdata (d_wdata),
		.re    (rd_en),
		.raddr (mod_bucket),
		.rdata (d_row)
	);

	// way compare and free-way pick
	always_comb begin
		logic [WAYS-1:0] free_vec;
		hit_handle = '0;
		d_wdata    = d_row;
		for (int w = 0; w < WAYS; w++) begin
			hit_vec[w] = v_row[w] && (d_row[w*WAY_W + HANDLE_W +: KW] == key_q);
			if (hit_vec[w]) begin
				hit_handle = hit_handle | d_row[w*WAY_W +: HANDLE_W];
			end
		end
		free_vec = ~v_row;
		low_free = free_vec & (~free_vec + 1'b1);
		for (int w = 0; w < WAYS; w++) begin
			if (low_free[w]) begin
				d_wdata[w*WAY_W +: WAY_W] = {key_q, hin_q};
			end
		end
	end

	// command outcome
	always_comb begin
		logic found;
		found     = |hit_vec;
		v_row_nxt = v_row;
		v_upd     = 1'b0;
		d_we      = 1'b0;
		cnt_nxt   = cnt_q;
		rsp_nxt.found      = found;
		rsp_nxt.handle_out = '0;
		rsp_nxt.status     = STAT_OK;
		unique case (cmd_q)
			CMD_INSERT: begin
				if (found) begin
					rsp_nxt.status = STAT_DUP;
				end else if (|low_free) begin
					v_row_nxt = v_row | low_free;
					v_upd     = 1'b1;
					d_we      = finish;
					cnt_nxt   = cnt_q + 1'b1;
				end else begin
					rsp_nxt.status = STAT_FULL;
				end
			end
			CMD_DELETE: begin
				if (found) begin
					v_row_nxt = v_row & ~hit_vec;
					v_upd     = 1'b1;
					cnt_nxt   = cnt_q - 1'b1;
				end else begin
					rsp_nxt.status = STAT_MISS;
				end
			end
			default: begin
				if (found) begin
					rsp_nxt.handle_out = hit_handle;
				end else begin
					rsp_nxt.status = STAT_MISS;
				end
			end
		endcase
		rsp_nxt.live_count = COUNT_W'(cnt_nxt);
	end

	always_comb begin
		if (state_q == S_CLEAR) begin
			v_we    = 1'b1;
			v_waddr = clr_q;
			v_wdata = '0;
		end else begin
			v_we    = finish && v_upd;
			v_waddr = bkt_q;
			v_wdata = v_row_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == LAST_ROW) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req.valid) begin
						state_q <= S_HASH;
					end
				end
				S_HASH: begin
					if (mod_done) begin
						state_q <= S_CMP;
					end
				end
				S_CMP: begin
					if (finish) begin
						state_q <= S_IDLE;
						cnt_q   <= cnt_nxt;
					end
				end
				default: begin
					state_q <= S_CLEAR;
				end
			endcase
			if (finish) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= req.data.command;
			key_q <= {req.data.entity_key, req.data.process_key};
			hin_q <= req.data.handle_in;
		end
		if (rd_en) begin
			bkt_q <= mod_bucket;
		end
		if (finish) begin
			rsp_q <= rsp_nxt;
		end
	end

endmodule

// ----- sv/hat_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks of the hashed actor table, bound to the top level.
// Depends on hat_pkg and hashed_actor_table_macros.svh.
`include "hashed_actor_table_macros.svh"
module hat_bound_checks (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         req_valid,
	input logic                         req_ready,
	input logic                         rsp_valid,
	input logic                         rsp_ready,
	input logic                         found,
	input logic [hat_pkg::HANDLE_W-1:0] handle_out,
	input logic [hat_pkg::STATUS_W-1:0] status
);
	import hat_pkg::*;

	`HAT_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "response dropped while stalled")
	`HAT_ASSERT_NEXT(a_req_gap, req_valid && req_ready, !req_ready, "request taken back to back")
	`HAT_ASSERT_NOW(a_found_status, rsp_valid && found, (status == STAT_OK) || (status == STAT_DUP), "hit with miss or full status")
	`HAT_ASSERT_NOW(a_handle_hit, rsp_valid && (handle_out != '0), found && (status == STAT_OK), "handle without a hit")

endmodule

bind hashed_actor_table hat_bound_checks u_hat_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_valid  (req.valid),
	.req_ready  (req.ready),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.found      (rsp.data.found),
	.handle_out (rsp.data.handle_out),
	.status     (rsp.data.status)
);
